>>> design/dma_tag_chain_checker_assert.svh
// Assertion macros for the DMA tag chain checker.
`ifndef DMA_TAG_CHAIN_CHECKER_ASSERT_SVH
`define DMA_TAG_CHAIN_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define DTC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define DTC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/dtc_pkg.sv
// Shared types and constants of the DMA tag chain checker.
package dtc_pkg;

	localparam int MAX_TAGS_DEF = 64;
	localparam logic [31:0] MEM_SIZE_RST = 32'h0200_0000;
	localparam logic [31:0] RSVD_MASK = 32'h8fff_0000;
	localparam logic [2:0] TAG_ID_CNT = 3'd1;
	localparam logic [2:0] TAG_ID_NEXT = 3'd2;
	localparam logic [32:0] QUAD_BYTES = 33'd16;

	typedef enum logic [3:0] {
		ERR_OK        = 4'd0,
		ERR_TAG_POS   = 4'd1,
		ERR_REVISIT   = 4'd2,
		ERR_FULL      = 4'd3,
		ERR_SPR_RSVD  = 4'd4,
		ERR_CNT_ADDR  = 4'd5,
		ERR_NEXT_ZERO = 4'd6,
		ERR_BAD_KIND  = 4'd7,
		ERR_PAYLOAD   = 4'd8,
		ERR_BAD_NEXT  = 4'd9
	} err_t;

	typedef struct packed {
		err_t        err;
		logic [31:0] next;
		logic [15:0] qwc;
		logic [2:0]  id;
		logic [19:0] payload;
		logic [32:0] data_off;
	} chk_t;

endpackage

>>> design/dtc_visit_mem.sv
// Visited-offset table with registered read and the shared offset comparator.
module dtc_visit_mem #(
	parameter int MAX_TAGS = dtc_pkg::MAX_TAGS_DEF,
	localparam int IW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	input  logic [31:0]   key,
	output logic          match_valid,
	output logic          match
);

	logic [31:0] mem [MAX_TAGS];
	logic [31:0] rd_data_q;
	logic        rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
		end
	end

	assign match_valid = rd_valid_q;
	assign match = rd_valid_q && (rd_data_q == key);

endmodule

>>> design/dtc_tag_check.sv
// Tag decode and the ordered acceptance checks once the loop scan is done.
module dtc_tag_check #(
	parameter int MAX_TAGS = dtc_pkg::MAX_TAGS_DEF,
	localparam int CW = $clog2(MAX_TAGS + 1)
) (
	input  logic [31:0]  cur_offset,
	input  logic [63:0]  tag,
	input  logic [CW-1:0] count,
	input  logic [31:0]  mem_size,
	input  logic         seen,
	output dtc_pkg::chk_t chk
);

	logic [30:0] addr;
	logic [32:0] data_off;
	logic [19:0] payload;
	logic [33:0] end_sum;
	logic [33:0] next_w;
	logic [2:0]  id;
	logic        bad_next;
	dtc_pkg::err_t err;

	assign id = tag[30:28];
	assign addr = tag[62:32];
	assign data_off = {1'b0, cur_offset} + dtc_pkg::QUAD_BYTES;
	assign payload = {tag[15:0], 4'b0000};
	// payload end doubles as the next offset of a cnt tag
	assign end_sum = {1'b0, data_off} + {14'b0, payload};
	assign next_w = (id == dtc_pkg::TAG_ID_CNT) ? end_sum : {3'b000, addr};
	assign bad_next = (next_w[33:32] != 2'b00) || (next_w[3:0] != 4'h0)
		|| (next_w > {2'b00, mem_size});

	always_comb begin
		err = dtc_pkg::ERR_OK;
		if (count >= CW'(MAX_TAGS)) begin
			err = dtc_pkg::ERR_FULL;
		end else if (cur_offset[3:0] != 4'h0) begin
			err = dtc_pkg::ERR_TAG_POS;
		end else if (data_off > {1'b0, mem_size}) begin
			err = dtc_pkg::ERR_TAG_POS;
		end else if (seen) begin
			err = dtc_pkg::ERR_REVISIT;
		end else if (tag[63] || ((tag[31:0] & dtc_pkg::RSVD_MASK) != 32'h0)) begin
			err = dtc_pkg::ERR_SPR_RSVD;
		end else if (id == dtc_pkg::TAG_ID_CNT) begin
			if (addr != 31'h0) begin
				err = dtc_pkg::ERR_CNT_ADDR;
			end
		end else if (id == dtc_pkg::TAG_ID_NEXT) begin
			if (addr == 31'h0) begin
				err = dtc_pkg::ERR_NEXT_ZERO;
			end
		end else begin
			err = dtc_pkg::ERR_BAD_KIND;
		end
		if (err == dtc_pkg::ERR_OK) begin
			if (end_sum > {2'b00, mem_size}) begin
				err = dtc_pkg::ERR_PAYLOAD;
			end else if (bad_next) begin
				err = dtc_pkg::ERR_BAD_NEXT;
			end
		end
	end

	always_comb begin
		chk.err = err;
		chk.next = next_w[31:0];
		chk.qwc = tag[15:0];
		chk.id = id;
		chk.payload = payload;
		chk.data_off = data_off;
	end

endmodule

>>> design/dma_tag_chain_checker.sv
// DMA tag chain checker top level: handshake, scan sequencer and result register.
// Start item: passes from the input straight to the check step, which loads the result.
// Tag item: the scan step does one table read per visited entry and drains the compare, then
// the check step runs and loads the result.
// One item at a time: input ready again as the result loads into the output register;
// an untaken result stalls the check step. Reset clears control, offset, count, size to 32 MiB.
`include "dma_tag_chain_checker_assert.svh"

module dma_tag_chain_checker #(
	parameter int MAX_TAGS = dtc_pkg::MAX_TAGS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] start_offset, [95:32] tag_word, [127:96] vif_word0, [159:128] vif_word1
	input  logic [159:0] s_tdata,
	// [0] kind
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [3:0] error_code, [19:4] quad_count, [22:20] tag_id, [42:23] payload_len,
	// [75:43] payload_off, [107:76] next_tag_off, [139:108] vif_out0,
	// [171:140] vif_out1, [175:172] zero
	output logic [175:0] m_tdata,
	// [0] accepted
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	localparam int CW = $clog2(MAX_TAGS + 1);
	localparam int IW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK
	} state_t;

	state_t        state_q;
	logic          kind_q;
	logic [31:0]   start_q;
	logic [63:0]   tag_q;
	logic [31:0]   vif0_q;
	logic [31:0]   vif1_q;
	logic [31:0]   cur_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_q;
	logic [31:0]   msize_q;
	logic          seen_q;

	logic          out_valid_q;
	logic          out_acc_q;
	dtc_pkg::err_t out_err_q;
	logic [15:0]   out_qwc_q;
	logic [2:0]    out_id_q;
	logic [19:0]   out_payload_q;
	logic [32:0]   out_doff_q;
	logic [31:0]   out_next_q;
	logic [31:0]   out_vif0_q;
	logic [31:0]   out_vif1_q;

	logic          in_xfer;
	logic          rd_en;
	logic          mem_wr;
	logic          match_valid;
	logic          match;
	logic          out_free;
	logic          out_load;
	logic          tag_ok;
	dtc_pkg::chk_t chk;

	assign in_xfer = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_CHECK) && out_free;
	assign rd_en = (state_q == ST_SCAN) && (issue_q < count_q);
	assign tag_ok = (chk.err == dtc_pkg::ERR_OK);
	assign mem_wr = out_load && kind_q && tag_ok;

	dtc_visit_mem #(
		.MAX_TAGS(MAX_TAGS)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(mem_wr),
		.wr_addr(count_q[IW-1:0]),
		.wr_data(cur_q),
		.rd_en(rd_en),
		.rd_addr(issue_q[IW-1:0]),
		.key(cur_q),
		.match_valid(match_valid),
		.match(match)
	);

	dtc_tag_check #(
		.MAX_TAGS(MAX_TAGS)
	) u_chk (
		.cur_offset(cur_q),
		.tag(tag_q),
		.count(count_q),
		.mem_size(msize_q),
		.seen(seen_q),
		.chk(chk)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			start_q <= s_tdata[31:0];
			tag_q <= s_tdata[95:32];
			vif0_q <= s_tdata[127:96];
			vif1_q <= s_tdata[159:128];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= 1'b0;
			cur_q <= 32'h0;
			count_q <= '0;
			issue_q <= '0;
			msize_q <= dtc_pkg::MEM_SIZE_RST;
			seen_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_acc_q <= 1'b0;
			out_err_q <= dtc_pkg::ERR_OK;
			out_qwc_q <= 16'h0;
			out_id_q <= 3'h0;
			out_payload_q <= 20'h0;
			out_doff_q <= 33'h0;
			out_next_q <= 32'h0;
			out_vif0_q <= 32'h0;
			out_vif1_q <= 32'h0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				msize_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q <= s_tuser[0];
						issue_q <= '0;
						seen_q <= 1'b0;
						state_q <= s_tuser[0] ? ST_SCAN : ST_CHECK;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + CW'(1);
					end
					if (match) begin
						seen_q <= 1'b1;
					end
					// leave once the last compare has drained
					if (!rd_en && !match_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!kind_q) begin
							cur_q <= start_q;
							count_q <= '0;
							out_acc_q <= 1'b0;
							out_err_q <= dtc_pkg::ERR_OK;
							out_qwc_q <= 16'h0;
							out_id_q <= 3'h0;
							out_payload_q <= 20'h0;
							out_doff_q <= 33'h0;
							out_next_q <= start_q;
							out_vif0_q <= 32'h0;
							out_vif1_q <= 32'h0;
						end else begin
							out_err_q <= chk.err;
							out_qwc_q <= chk.qwc;
							out_id_q <= chk.id;
							out_payload_q <= chk.payload;
							out_doff_q <= chk.data_off;
							if (tag_ok) begin
								cur_q <= chk.next;
								count_q <= count_q + CW'(1);
								out_acc_q <= 1'b1;
								out_next_q <= chk.next;
								out_vif0_q <= vif0_q;
								out_vif1_q <= vif1_q;
							end else begin
								out_acc_q <= 1'b0;
								out_next_q <= 32'h0;
								out_vif0_q <= 32'h0;
								out_vif1_q <= 32'h0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_acc_q;
	assign m_tdata = {4'h0, out_vif1_q, out_vif0_q, out_next_q, out_doff_q,
		out_payload_q, out_id_q, out_qwc_q, out_err_q};

	`DTC_ASSERT(a_acc_no_err, clk, arst_n, out_valid_q && out_acc_q |-> out_err_q == dtc_pkg::ERR_OK, "accepted result carries an error code")
	`DTC_ASSERT(a_count_on_acc, clk, arst_n, (count_q != $past(count_q)) && (count_q != '0) |-> out_valid_q && out_acc_q, "visited count moved without an accepted tag")
	`DTC_ASSERT(a_busy_after_xfer, clk, arst_n, in_xfer |=> !s_tready, "input taken again before the item finished")
	`DTC_ASSERT_ALWAYS(a_wr_rd_excl, clk, !(mem_wr && rd_en), "table write during scan read")

endmodule
